>>> sv/mesh_command_list_vertex_decoder_macros.svh
// Assertion helpers for the vertex decoder
`ifndef MESH_COMMAND_LIST_VERTEX_DECODER_MACROS_SVH
`define MESH_COMMAND_LIST_VERTEX_DECODER_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define MCLVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check with next-cycle consequent
`define MCLVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mclvd_pkg.sv
package mclvd_pkg;

    localparam int VertexSlotsDef = 2048;
    localparam int NormalCount = 162;
    localparam int PosW = 20;
    localparam int NormW = 16;
    localparam int WordW = 32;
    localparam int WeightW = 17;
    localparam int QDepth = 4;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_CMD = 1'b1;

    localparam logic [0:0] ADDR_WEIGHT = 1'b0;

    // item classified by the front end, handed to the back end
    // loads carry {normal index, cur xyz, nxt xyz} in data
    typedef struct packed {
        logic            ld;
        logic            eol;
        logic            fan;
        logic            last;
        logic [31:0]     u;
        logic [31:0]     v;
        logic            idx_ok;
        logic [15:0]     idx;
        logic [127:0]    data;
    } vtx_cmd_t;

    localparam logic signed [15:0] Q53 = 16'sd8614;
    localparam logic signed [15:0] Q85 = 16'sd13937;
    localparam logic signed [15:0] Q44 = 16'sd7256;
    localparam logic signed [15:0] Q24 = 16'sd3913;
    localparam logic signed [15:0] Q86 = 16'sd14159;
    localparam logic signed [15:0] Q30 = 16'sd4837;
    localparam logic signed [15:0] Q96 = 16'sd15654;
    localparam logic signed [15:0] Q31 = 16'sd5063;
    localparam logic signed [15:0] Q50 = 16'sd8192;
    localparam logic signed [15:0] Q81 = 16'sd13255;
    localparam logic signed [15:0] Q16 = 16'sd2662;
    localparam logic signed [15:0] Q26 = 16'sd4307;
    localparam logic signed [15:0] Q95 = 16'sd15582;
    localparam logic signed [15:0] Q100 = 16'sd16384;
    localparam logic signed [15:0] Q15 = 16'sd2419;
    localparam logic signed [15:0] Q72 = 16'sd11740;
    localparam logic signed [15:0] Q68 = 16'sd11169;
    localparam logic signed [15:0] Q59 = 16'sd9630;
    localparam logic signed [15:0] Q43 = 16'sd6969;
    localparam logic signed [15:0] Q69 = 16'sd11275;
    localparam logic signed [15:0] Z = 16'sd0;

    typedef logic signed [15:0] nvec_t [3];

    function automatic logic [47:0] nv(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic signed [15:0] c);
        nv = {a, b, c};
    endfunction

    // unit normal table, x in the top 16 bits; zero outside the table
    function automatic logic [47:0] normal_lut(input logic [7:0] i);
        case (i)
            8'd0: normal_lut = nv(-Q53, Z, Q85);
            8'd1: normal_lut = nv(-Q44, Q24, Q86);
            8'd2: normal_lut = nv(-Q30, Z, Q96);
            8'd3: normal_lut = nv(-Q31, Q50, Q81);
            8'd4: normal_lut = nv(-Q16, Q26, Q95);
            8'd5: normal_lut = nv(Z, Z, Q100);
            8'd6: normal_lut = nv(Z, Q85, Q53);
            8'd7: normal_lut = nv(-Q15, Q72, Q68);
            8'd8: normal_lut = nv(Q15, Q72, Q68);
            8'd9: normal_lut = nv(Z, Q53, Q85);
            8'd10: normal_lut = nv(Q31, Q50, Q81);
            8'd11: normal_lut = nv(Q53, Z, Q85);
            8'd12: normal_lut = nv(Q30, Z, Q96);
            8'd13: normal_lut = nv(Q44, Q24, Q86);
            8'd14: normal_lut = nv(Q16, Q26, Q95);
            8'd15: normal_lut = nv(-Q68, Q15, Q72);
            8'd16: normal_lut = nv(-Q81, Q31, Q50);
            8'd17: normal_lut = nv(-Q59, Q43, Q69);
            8'd18: normal_lut = nv(-Q85, Q53, Z);
            8'd19: normal_lut = nv(-Q86, Q44, Q24);
            8'd20: normal_lut = nv(-Q72, Q68, Q15);
            8'd21: normal_lut = nv(-Q69, Q59, Q43);
            8'd22: normal_lut = nv(-Q50, Q81, Q31);
            8'd23: normal_lut = nv(-Q24, Q86, Q44);
            8'd24: normal_lut = nv(-Q43, Q69, Q59);
            8'd25: normal_lut = nv(-Q72, Q68, -Q15);
            8'd26: normal_lut = nv(-Q50, Q81, -Q31);
            8'd27: normal_lut = nv(-Q53, Q85, Z);
            8'd28: normal_lut = nv(Z, Q85, -Q53);
            8'd29: normal_lut = nv(-Q24, Q86, -Q44);
            8'd30: normal_lut = nv(Z, Q96, -Q30);
            8'd31: normal_lut = nv(-Q26, Q95, -Q16);
            8'd32: normal_lut = nv(Z, Q100, Z);
            8'd33: normal_lut = nv(Z, Q96, Q30);
            8'd34: normal_lut = nv(-Q26, Q95, Q16);
            8'd35: normal_lut = nv(Q24, Q86, Q44);
            8'd36: normal_lut = nv(Q26, Q95, Q16);
            8'd37: normal_lut = nv(Q50, Q81, Q31);
            8'd38: normal_lut = nv(Q24, Q86, -Q44);
            8'd39: normal_lut = nv(Q26, Q95, -Q16);
            8'd40: normal_lut = nv(Q50, Q81, -Q31);
            8'd41: normal_lut = nv(Q85, Q53, Z);
            8'd42: normal_lut = nv(Q72, Q68, Q15);
            8'd43: normal_lut = nv(Q72, Q68, -Q15);
            8'd44: normal_lut = nv(Q53, Q85, Z);
            8'd45: normal_lut = nv(Q43, Q69, Q59);
            8'd46: normal_lut = nv(Q86, Q44, Q24);
            8'd47: normal_lut = nv(Q69, Q59, Q43);
            8'd48: normal_lut = nv(Q81, Q31, Q50);
            8'd49: normal_lut = nv(Q68, Q15, Q72);
            8'd50: normal_lut = nv(Q59, Q43, Q69);
            8'd51: normal_lut = nv(Q96, Q30, Z);
            8'd52: normal_lut = nv(Q100, Z, Z);
            8'd53: normal_lut = nv(Q95, Q16, Q26);
            8'd54: normal_lut = nv(Q85, -Q53, Z);
            8'd55: normal_lut = nv(Q96, -Q30, Z);
            8'd56: normal_lut = nv(Q86, -Q44, Q24);
            8'd57: normal_lut = nv(Q95, -Q16, Q26);
            8'd58: normal_lut = nv(Q81, -Q31, Q50);
            8'd59: normal_lut = nv(Q68, -Q15, Q72);
            8'd60: normal_lut = nv(Q85, Z, Q53);
            8'd61: normal_lut = nv(Q86, Q44, -Q24);
            8'd62: normal_lut = nv(Q81, Q31, -Q50);
            8'd63: normal_lut = nv(Q95, Q16, -Q26);
            8'd64: normal_lut = nv(Q53, Z, -Q85);
            8'd65: normal_lut = nv(Q68, Q15, -Q72);
            8'd66: normal_lut = nv(Q68, -Q15, -Q72);
            8'd67: normal_lut = nv(Q85, Z, -Q53);
            8'd68: normal_lut = nv(Q81, -Q31, -Q50);
            8'd69: normal_lut = nv(Q86, -Q44, -Q24);
            8'd70: normal_lut = nv(Q95, -Q16, -Q26);
            8'd71: normal_lut = nv(Q15, Q72, -Q68);
            8'd72: normal_lut = nv(Q31, Q50, -Q81);
            8'd73: normal_lut = nv(Q43, Q69, -Q59);
            8'd74: normal_lut = nv(Q44, Q24, -Q86);
            8'd75: normal_lut = nv(Q59, Q43, -Q69);
            8'd76: normal_lut = nv(Q69, Q59, -Q43);
            8'd77: normal_lut = nv(-Q15, Q72, -Q68);
            8'd78: normal_lut = nv(-Q31, Q50, -Q81);
            8'd79: normal_lut = nv(Z, Q53, -Q85);
            8'd80: normal_lut = nv(-Q53, Z, -Q85);
            8'd81: normal_lut = nv(-Q44, Q24, -Q86);
            8'd82: normal_lut = nv(-Q30, Z, -Q96);
            8'd83: normal_lut = nv(-Q16, Q26, -Q95);
            8'd84: normal_lut = nv(Z, Z, -Q100);
            8'd85: normal_lut = nv(Q30, Z, -Q96);
            8'd86: normal_lut = nv(Q16, Q26, -Q95);
            8'd87: normal_lut = nv(-Q44, -Q24, -Q86);
            8'd88: normal_lut = nv(-Q31, -Q50, -Q81);
            8'd89: normal_lut = nv(-Q16, -Q26, -Q95);
            8'd90: normal_lut = nv(Z, -Q85, -Q53);
            8'd91: normal_lut = nv(-Q15, -Q72, -Q68);
            8'd92: normal_lut = nv(Q15, -Q72, -Q68);
            8'd93: normal_lut = nv(Z, -Q53, -Q85);
            8'd94: normal_lut = nv(Q31, -Q50, -Q81);
            8'd95: normal_lut = nv(Q44, -Q24, -Q86);
            8'd96: normal_lut = nv(Q16, -Q26, -Q95);
            8'd97: normal_lut = nv(Q24, -Q86, -Q44);
            8'd98: normal_lut = nv(Q50, -Q81, -Q31);
            8'd99: normal_lut = nv(Q43, -Q69, -Q59);
            8'd100: normal_lut = nv(Q72, -Q68, -Q15);
            8'd101: normal_lut = nv(Q69, -Q59, -Q43);
            8'd102: normal_lut = nv(Q59, -Q43, -Q69);
            8'd103: normal_lut = nv(Z, -Q96, -Q30);
            8'd104: normal_lut = nv(Z, -Q100, Z);
            8'd105: normal_lut = nv(Q26, -Q95, -Q16);
            8'd106: normal_lut = nv(Z, -Q85, Q53);
            8'd107: normal_lut = nv(Z, -Q96, Q30);
            8'd108: normal_lut = nv(Q24, -Q86, Q44);
            8'd109: normal_lut = nv(Q26, -Q95, Q16);
            8'd110: normal_lut = nv(Q50, -Q81, Q31);
            8'd111: normal_lut = nv(Q72, -Q68, Q15);
            8'd112: normal_lut = nv(Q53, -Q85, Z);
            8'd113: normal_lut = nv(-Q24, -Q86, -Q44);
            8'd114: normal_lut = nv(-Q50, -Q81, -Q31);
            8'd115: normal_lut = nv(-Q26, -Q95, -Q16);
            8'd116: normal_lut = nv(-Q85, -Q53, Z);
            8'd117: normal_lut = nv(-Q72, -Q68, -Q15);
            8'd118: normal_lut = nv(-Q72, -Q68, Q15);
            8'd119: normal_lut = nv(-Q53, -Q85, Z);
            8'd120: normal_lut = nv(-Q50, -Q81, Q31);
            8'd121: normal_lut = nv(-Q24, -Q86, Q44);
            8'd122: normal_lut = nv(-Q26, -Q95, Q16);
            8'd123: normal_lut = nv(-Q86, -Q44, Q24);
            8'd124: normal_lut = nv(-Q81, -Q31, Q50);
            8'd125: normal_lut = nv(-Q69, -Q59, Q43);
            8'd126: normal_lut = nv(-Q68, -Q15, Q72);
            8'd127: normal_lut = nv(-Q44, -Q24, Q86);
            8'd128: normal_lut = nv(-Q59, -Q43, Q69);
            8'd129: normal_lut = nv(-Q31, -Q50, Q81);
            8'd130: normal_lut = nv(-Q15, -Q72, Q68);
            8'd131: normal_lut = nv(-Q43, -Q69, Q59);
            8'd132: normal_lut = nv(-Q16, -Q26, Q95);
            8'd133: normal_lut = nv(Q44, -Q24, Q86);
            8'd134: normal_lut = nv(Q16, -Q26, Q95);
            8'd135: normal_lut = nv(Q31, -Q50, Q81);
            8'd136: normal_lut = nv(Q15, -Q72, Q68);
            8'd137: normal_lut = nv(Z, -Q53, Q85);
            8'd138: normal_lut = nv(Q43, -Q69, Q59);
            8'd139: normal_lut = nv(Q59, -Q43, Q69);
            8'd140: normal_lut = nv(Q69, -Q59, Q43);
            8'd141: normal_lut = nv(-Q96, Q30, Z);
            8'd142: normal_lut = nv(-Q95, Q16, Q26);
            8'd143: normal_lut = nv(-Q100, Z, Z);
            8'd144: normal_lut = nv(-Q85, Z, Q53);
            8'd145: normal_lut = nv(-Q96, -Q30, Z);
            8'd146: normal_lut = nv(-Q95, -Q16, Q26);
            8'd147: normal_lut = nv(-Q86, Q44, -Q24);
            8'd148: normal_lut = nv(-Q95, Q16, -Q26);
            8'd149: normal_lut = nv(-Q81, Q31, -Q50);
            8'd150: normal_lut = nv(-Q86, -Q44, -Q24);
            8'd151: normal_lut = nv(-Q95, -Q16, -Q26);
            8'd152: normal_lut = nv(-Q81, -Q31, -Q50);
            8'd153: normal_lut = nv(-Q68, Q15, -Q72);
            8'd154: normal_lut = nv(-Q68, -Q15, -Q72);
            8'd155: normal_lut = nv(-Q85, Z, -Q53);
            8'd156: normal_lut = nv(-Q69, Q59, -Q43);
            8'd157: normal_lut = nv(-Q59, Q43, -Q69);
            8'd158: normal_lut = nv(-Q43, Q69, -Q59);
            8'd159: normal_lut = nv(-Q43, -Q69, -Q59);
            8'd160: normal_lut = nv(-Q59, -Q43, -Q69);
            8'd161: normal_lut = nv(-Q69, -Q59, -Q43);
            default: normal_lut = '0;
        endcase
    endfunction

endpackage

>>> sv/mclvd_front.sv
module mclvd_front #(
    parameter int VERTEX_SLOTS = mclvd_pkg::VertexSlotsDef
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 op,
    input  logic [31:0]          cmd_word,
    input  logic [10:0]          load_index,
    input  logic [127:0]         load_data,
    output logic                 push,
    output mclvd_pkg::vtx_cmd_t  push_data
);
    import mclvd_pkg::*;

    typedef enum logic [1:0] {PH_COUNT, PH_U, PH_V, PH_INDEX} phase_t;

    phase_t      phase_reg;
    logic [15:0] left_reg;
    logic        fan_reg;
    logic [31:0] u_reg;
    logic [31:0] v_reg;

    logic [31:0] mag;
    logic [15:0] left_dec;
    logic        is_cmd;
    logic        is_load;

    assign is_cmd = in_fire && (op == OP_CMD);
    assign is_load = in_fire && (op == OP_LOAD);
    assign mag = cmd_word[31] ? (~cmd_word + 32'd1) : cmd_word;
    assign left_dec = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;

    // output record for a store load, end of list or a completed vertex
    always_comb
    begin
        push = 1'b0;
        push_data = '0;
        if (is_load)
        begin
            push = 1'b1;
            push_data.ld = 1'b1;
            push_data.idx_ok = (32'(load_index) < 32'(VERTEX_SLOTS));
            push_data.idx = {5'd0, load_index};
            push_data.data = load_data;
        end
        else if (is_cmd && phase_reg == PH_COUNT && cmd_word == 32'd0)
        begin
            push = 1'b1;
            push_data.eol = 1'b1;
        end
        else if (is_cmd && phase_reg == PH_INDEX)
        begin
            push = 1'b1;
            push_data.fan = fan_reg;
            push_data.last = (left_dec == 16'd0);
            push_data.u = u_reg;
            push_data.v = v_reg;
            push_data.idx_ok = ({1'b0, cmd_word} < 33'(VERTEX_SLOTS));
            push_data.idx = cmd_word[15:0];
        end
    end

    // command parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            left_reg <= '0;
            fan_reg <= 1'b0;
            u_reg <= '0;
            v_reg <= '0;
        end
        else if (is_cmd)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (cmd_word != 32'd0)
                    begin
                        fan_reg <= cmd_word[31];
                        left_reg <= (mag > 32'd65535) ? 16'hFFFF : mag[15:0];
                        phase_reg <= PH_U;
                    end
                end
                PH_U:
                begin
                    u_reg <= cmd_word;
                    phase_reg <= PH_V;
                end
                PH_V:
                begin
                    v_reg <= cmd_word;
                    phase_reg <= PH_INDEX;
                end
                PH_INDEX:
                begin
                    left_reg <= left_dec;
                    phase_reg <= (left_dec == 16'd0) ? PH_COUNT : PH_U;
                end
                default: phase_reg <= PH_COUNT;
            endcase
        end
    end
endmodule

>>> sv/mclvd_queue.sv
module mclvd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mclvd_pkg::vtx_cmd_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output mclvd_pkg::vtx_cmd_t  head
);
    import mclvd_pkg::*;

    localparam int AW = $clog2(QDepth);

    vtx_cmd_t     mem_reg [QDepth];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;

    assign full = (cnt_reg == (AW+1)'(QDepth));
    assign valid = (cnt_reg != '0);
    assign head = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> sv/mclvd_back.sv
module mclvd_back #(
    parameter int VERTEX_SLOTS = mclvd_pkg::VertexSlotsDef
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [16:0]           weight,
    input  logic                  q_valid,
    input  mclvd_pkg::vtx_cmd_t   q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  prim_fan,
    output logic signed [31:0]    tex_u,
    output logic signed [31:0]    tex_v,
    output logic signed [15:0]    norm_x,
    output logic signed [15:0]    norm_y,
    output logic signed [15:0]    norm_z,
    output logic signed [19:0]    pos_x,
    output logic signed [19:0]    pos_y,
    output logic signed [19:0]    pos_z,
    output logic                  last_in_prim,
    output logic                  end_of_list
);
    import mclvd_pkg::*;

    localparam int IW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

    // vertex store: two frames of xyz and the normal index
    logic [127:0] store_mem [VERTEX_SLOTS];
    logic [127:0] rd_reg;

    logic         s1_valid_reg;
    vtx_cmd_t     s1_reg;
    logic         s2_valid_reg;
    vtx_cmd_t     s2_reg;
    logic signed [19:0] s2_c_reg [3];
    logic signed [37:0] s2_p_reg [3];
    logic [47:0]  s2_n_reg;
    logic         advance;
    logic         st_wr;
    logic [16:0]  w_sat;

    assign w_sat = (weight > 17'd65536) ? 17'd65536 : weight;

    // pipeline moves when the output slot is free or being drained
    assign advance = !out_valid || out_ready;
    assign q_pop = q_valid && advance;

    // loads leave the queue in order with vertex reads
    assign st_wr = q_pop && q_head.ld && q_head.idx_ok;

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (st_wr)
        begin
            store_mem[q_head.idx[IW-1:0]] <= q_head.data;
        end
        if (advance)
        begin
            rd_reg <= store_mem[q_head.idx[IW-1:0]];
        end
    end

    // stage registers; loads produce no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid && !q_head.ld;
            s2_valid_reg <= s1_valid_reg;
            out_valid <= s2_valid_reg;
        end
    end

    // stage 1 -> 2: difference times weight
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= q_head;
            s2_reg <= s1_reg;
            s2_n_reg <= normal_lut(rd_reg[127:120]);
            for (int k = 0; k < 3; k++)
            begin
                s2_c_reg[k] <= rd_reg[60 + 20*(2-k) +: 20];
                s2_p_reg[k] <= (21'(signed'(rd_reg[20*(2-k) +: 20]))
                               - 21'(signed'(rd_reg[60 + 20*(2-k) +: 20])))
                               * signed'({1'b0, w_sat});
            end
        end
    end

    logic signed [37:0] rnd [3];
    logic signed [19:0] pos [3];
    logic signed [32:0] tv;
    logic               ok;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = s2_p_reg[k] + 38'sd32768;
            pos[k] = s2_c_reg[k] + 20'(rnd[k] >>> 16);
        end
        tv = 33'sd65536 - 33'(signed'(s2_reg.v));
        ok = s2_reg.idx_ok && !s2_reg.eol;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prim_fan <= s2_reg.fan;
            tex_u <= s2_reg.u;
            if (s2_reg.eol)
            begin
                tex_v <= '0;
            end
            else
            begin
                tex_v <= (tv > 33'sd2147483647) ? 32'h7FFFFFFF : tv[31:0];
            end
            norm_x <= ok ? s2_n_reg[47:32] : '0;
            norm_y <= ok ? s2_n_reg[31:16] : '0;
            norm_z <= ok ? s2_n_reg[15:0] : '0;
            pos_x <= ok ? pos[0] : '0;
            pos_y <= ok ? pos[1] : '0;
            pos_z <= ok ? pos[2] : '0;
            last_in_prim <= s2_reg.last;
            end_of_list <= s2_reg.eol;
        end
    end
endmodule

>>> sv/mesh_command_list_vertex_decoder.sv
// channel   | handshake           | payload
// in        | in_valid / in_ready | op, cmd_word, load_index, cur_*, nxt_*, normal_sel
// out       | out_valid/out_ready | prim_fan, tex_u/v, norm_*, pos_*, last_in_prim, end_of_list
// config    | APB write           | interp_weight at address 0
// One transaction per cycle in while the queue has room; an accepted index word is written to the
// queue at the accept, then its vertex passes the store read, multiply and output register.
// Load transactions pass through the queue and write the store in order with vertex reads.
// Reset clears the parser, queue and output valid; the store is not cleared.
// The front stalls only when the four-entry queue is full.
module mesh_command_list_vertex_decoder #(
    parameter int VERTEX_SLOTS = mclvd_pkg::VertexSlotsDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] cmd_word,
    input  logic [10:0]        load_index,
    input  logic signed [19:0] cur_x,
    input  logic signed [19:0] cur_y,
    input  logic signed [19:0] cur_z,
    input  logic signed [19:0] nxt_x,
    input  logic signed [19:0] nxt_y,
    input  logic signed [19:0] nxt_z,
    input  logic [7:0]         normal_sel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               prim_fan,
    output logic signed [31:0] tex_u,
    output logic signed [31:0] tex_v,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic signed [19:0] pos_x,
    output logic signed [19:0] pos_y,
    output logic signed [19:0] pos_z,
    output logic               last_in_prim,
    output logic               end_of_list
);
    import mclvd_pkg::*;
`include "mesh_command_list_vertex_decoder_macros.svh"

    logic [16:0] weight_reg;
    logic        in_fire;
    logic        push;
    vtx_cmd_t    push_data;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    vtx_cmd_t    q_head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WEIGHT) ? {15'd0, weight_reg} : '0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_WEIGHT)
        begin
            weight_reg <= pwdata[16:0];
        end
    end

    assign in_ready = !q_full;
    assign in_fire = in_valid && in_ready;

    mclvd_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(op),
        .cmd_word(cmd_word), .load_index(load_index),
        .load_data({normal_sel, cur_x, cur_y, cur_z, nxt_x, nxt_y, nxt_z}),
        .push(push), .push_data(push_data)
    );

    mclvd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .full(q_full), .pop(q_pop), .valid(q_valid), .head(q_head)
    );

    mclvd_back #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .weight(weight_reg), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready), .prim_fan(prim_fan),
        .tex_u(tex_u), .tex_v(tex_v), .norm_x(norm_x), .norm_y(norm_y),
        .norm_z(norm_z), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .last_in_prim(last_in_prim), .end_of_list(end_of_list)
    );

    `MCLVD_ASSERT(a_no_push_full, !(push && q_full && !q_pop), "queue overflow")
    `MCLVD_ASSERT(a_eol_clean, !(out_valid && end_of_list) || tex_u == 0, "end of list not clean")
    `MCLVD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(tex_u), "output dropped")
endmodule
